FILE: src/csl_pkg.sv
// Shared types and constants for the C subset lexer.
`timescale 1ns / 1ps

package csl_pkg;

  // Token kinds
  localparam logic [4:0] KIND_PUNCT    = 5'd0;
  localparam logic [4:0] KIND_NUMBER   = 5'd1;
  localparam logic [4:0] KIND_IDENT    = 5'd2;
  localparam logic [4:0] KIND_IF       = 5'd3;
  localparam logic [4:0] KIND_ELSE     = 5'd4;
  localparam logic [4:0] KIND_WHILE    = 5'd5;
  localparam logic [4:0] KIND_TYPE     = 5'd6;
  localparam logic [4:0] KIND_RETURN   = 5'd7;
  localparam logic [4:0] KIND_EQ       = 5'd8;
  localparam logic [4:0] KIND_NE       = 5'd9;
  localparam logic [4:0] KIND_SHL      = 5'd10;
  localparam logic [4:0] KIND_SHR      = 5'd11;
  localparam logic [4:0] KIND_INC      = 5'd12;
  localparam logic [4:0] KIND_DEC      = 5'd13;
  localparam logic [4:0] KIND_OPASSIGN = 5'd14;
  localparam logic [4:0] KIND_EOF      = 5'd15;
  localparam logic [4:0] KIND_ERROR    = 5'd16;

  localparam logic [7:0] TYPE_INT  = 8'd0;
  localparam logic [7:0] TYPE_CHAR = 8'd1;

  localparam logic [62:0] NUM_LIMIT = 63'h7FFF_FFFF_FFFF_FFFF;

  localparam int MAX_IDENT_LEN_DEF = 255;
  localparam int POS_WIDTH_DEF     = 16;

  // Bundle queue depth, power of two
  localparam int QDEPTH = 4;

  typedef struct packed {
    logic [4:0]  kind;
    logic [7:0]  detail;
    logic [62:0] num;
    logic [15:0] start;
    logic [7:0]  len;
  } tok_t;

  // Tokens caused by one character, in order, at most three; count is 1 to 3
  typedef struct packed {
    logic [1:0]     count;
    tok_t [2:0]     tok;
  } bundle_t;

endpackage

FILE: src/csl_queue.sv
// Small queue of token bundles between the scanner and the serializer.
`timescale 1ns / 1ps

module csl_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  csl_pkg::bundle_t  wr_data,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output csl_pkg::bundle_t  head
);
  import csl_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  bundle_t            store [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full  = (count == CNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign head  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/csl_front.sv
// Scanner: consumes one character per cycle while the queue is not full and builds the bundle of tokens it causes.
`timescale 1ns / 1ps

module csl_front #(
  parameter int MAX_IDENT_LEN = csl_pkg::MAX_IDENT_LEN_DEF,
  parameter int POS_WIDTH     = csl_pkg::POS_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [7:0]        ch,
  input  logic              end_of_text,
  input  logic              q_full,
  output logic              q_push,
  output csl_pkg::bundle_t  q_data
);
  import csl_pkg::*;

  typedef enum logic [1:0] {M_IDLE, M_OP, M_NUM, M_IDENT} mode_t;

  // Keyword bytes reversed: the first character sits in the low byte
  localparam logic [15:0] KW_IF     = "fi";
  localparam logic [31:0] KW_ELSE   = "esle";
  localparam logic [39:0] KW_WHILE  = "elihw";
  localparam logic [23:0] KW_INT    = "tni";
  localparam logic [31:0] KW_CHAR   = "rahc";
  localparam logic [47:0] KW_RETURN = "nruter";

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_opassign_lead(input logic [7:0] c);
    return (c == "+") || (c == "-") || (c == "*") || (c == "/") ||
           (c == "%") || (c == "^") || (c == "|") || (c == "&");
  endfunction

  function automatic logic is_lead(input logic [7:0] c);
    return is_opassign_lead(c) || (c == "=") || (c == "!") || (c == "<") || (c == ">");
  endfunction

  function automatic logic is_single_punct(input logic [7:0] c);
    return (c == "(") || (c == ")") || (c == ";") || (c == ",") || (c == "{") ||
           (c == "}") || (c == "?") || (c == ":") || (c == "[") || (c == "]");
  endfunction

  function automatic logic [15:0] pos16(input logic [POS_WIDTH-1:0] p);
    logic [31:0] e;
    e = 32'(p);
    return e[15:0];
  endfunction

  function automatic tok_t make_tok(input logic [4:0] k, input logic [7:0] d,
                                    input logic [62:0] n, input logic [POS_WIDTH-1:0] s,
                                    input logic [7:0] l);
    tok_t t;
    t.kind   = k;
    t.detail = d;
    t.num    = n;
    t.start  = pos16(s);
    t.len    = l;
    return t;
  endfunction

  // Token for whatever is pending in the given scan state
  function automatic tok_t flush_tok(input mode_t m, input logic [7:0] pend,
                                     input logic [POS_WIDTH-1:0] st, input logic [7:0] len,
                                     input logic [62:0] acc, input logic [47:0] pre,
                                     input logic ovf);
    tok_t       t;
    logic [4:0] k;
    logic [7:0] d;
    k = KIND_IDENT;
    d = 8'd0;
    if ((len == 8'd2) && (pre[15:0] == KW_IF)) begin
      k = KIND_IF;
    end else if ((len == 8'd4) && (pre[31:0] == KW_ELSE)) begin
      k = KIND_ELSE;
    end else if ((len == 8'd5) && (pre[39:0] == KW_WHILE)) begin
      k = KIND_WHILE;
    end else if ((len == 8'd3) && (pre[23:0] == KW_INT)) begin
      k = KIND_TYPE;
      d = TYPE_INT;
    end else if ((len == 8'd4) && (pre[31:0] == KW_CHAR)) begin
      k = KIND_TYPE;
      d = TYPE_CHAR;
    end else if ((len == 8'd6) && (pre == KW_RETURN)) begin
      k = KIND_RETURN;
    end
    unique case (m)
      M_IDLE:  t = make_tok(KIND_PUNCT, pend, 63'd0, st, 8'd1);
      M_OP:    t = make_tok(KIND_PUNCT, pend, 63'd0, st, 8'd1);
      M_NUM:   t = make_tok(KIND_NUMBER, 8'd0, acc, st, len);
      M_IDENT: begin
        if (ovf) begin
          t = make_tok(KIND_ERROR, 8'd0, 63'd0, st, len);
        end else begin
          t = make_tok(k, d, 63'd0, st, len);
        end
      end
    endcase
    return t;
  endfunction

  mode_t                 mode, mode_next;
  logic [7:0]            pending_char, pending_char_next;
  logic [POS_WIDTH-1:0]  token_start, token_start_next;
  logic [POS_WIDTH-1:0]  char_index, char_index_next;
  logic [7:0]            ident_len, ident_len_next;
  logic [62:0]           number_acc, number_acc_next;
  logic [47:0]           keyword_prefix, keyword_prefix_next;
  logic                  overflow_flag, overflow_flag_next;

  logic                  take;
  logic [3:0]            digit;
  logic [66:0]           num_sum;
  logic                  gen;
  logic [4:0]            pair_kind;
  logic                  pair_hit;
  tok_t [3:0]            cand;
  logic [3:0]            cand_v;
  logic [2:0]            n_tok;

  assign take    = push && !q_full;
  assign digit   = ch[3:0];
  assign num_sum = 67'({number_acc, 3'b000}) + 67'({number_acc, 1'b0}) + 67'(digit);

  always_comb begin
    pair_hit  = 1'b1;
    pair_kind = KIND_INC;
    priority if ((pending_char == "+") && (ch == "+")) begin
      pair_kind = KIND_INC;
    end else if ((pending_char == "-") && (ch == "-")) begin
      pair_kind = KIND_DEC;
    end else if ((pending_char == "=") && (ch == "=")) begin
      pair_kind = KIND_EQ;
    end else if ((pending_char == "!") && (ch == "=")) begin
      pair_kind = KIND_NE;
    end else if ((pending_char == "<") && (ch == "<")) begin
      pair_kind = KIND_SHL;
    end else if ((pending_char == ">") && (ch == ">")) begin
      pair_kind = KIND_SHR;
    end else begin
      pair_hit = 1'b0;
    end
  end

  always_comb begin
    mode_next           = mode;
    pending_char_next   = pending_char;
    token_start_next    = token_start;
    char_index_next     = char_index;
    ident_len_next      = ident_len;
    number_acc_next     = number_acc;
    keyword_prefix_next = keyword_prefix;
    overflow_flag_next  = overflow_flag;
    gen                 = 1'b0;
    cand                = '0;
    cand_v              = '0;

    // NUL is no character at all
    if (ch != 8'd0) begin
      char_index_next = char_index + POS_WIDTH'(1);
      unique case (mode)
        M_IDLE: gen = 1'b1;
        M_OP: begin
          mode_next = M_IDLE;
          if ((ch == "=") && is_opassign_lead(pending_char)) begin
            // compound assignment: '=' first, then the operator
            cand[0]   = make_tok(KIND_PUNCT, "=", 63'd0, char_index, 8'd1);
            cand[1]   = make_tok(KIND_OPASSIGN, pending_char, 63'd0, token_start, 8'd1);
            cand_v[1:0] = 2'b11;
          end else if (pair_hit) begin
            cand[0]   = make_tok(pair_kind, 8'd0, 63'd0, token_start, 8'd2);
            cand_v[0] = 1'b1;
          end else begin
            cand[0]   = make_tok(KIND_PUNCT, pending_char, 63'd0, token_start, 8'd1);
            cand_v[0] = 1'b1;
            gen       = 1'b1;
          end
        end
        M_NUM: begin
          if (is_digit(ch)) begin
            if (num_sum > 67'(NUM_LIMIT)) begin
              number_acc_next    = NUM_LIMIT;
              overflow_flag_next = 1'b1;
            end else begin
              number_acc_next = num_sum[62:0];
            end
            if (ident_len != 8'd255) begin
              ident_len_next = ident_len + 8'd1;
            end
          end else begin
            cand[0]   = flush_tok(mode, pending_char, token_start, ident_len,
                                  number_acc, keyword_prefix, overflow_flag);
            cand_v[0] = 1'b1;
            mode_next = M_IDLE;
            gen       = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_letter(ch) || is_digit(ch)) begin
            if (ident_len < 8'(MAX_IDENT_LEN)) begin
              for (int i = 0; i < 6; i++) begin
                if (ident_len == 8'(i)) begin
                  keyword_prefix_next[8*i +: 8] = ch;
                end
              end
              ident_len_next = ident_len + 8'd1;
            end else begin
              overflow_flag_next = 1'b1;
            end
          end else begin
            cand[0]   = flush_tok(mode, pending_char, token_start, ident_len,
                                  number_acc, keyword_prefix, overflow_flag);
            cand_v[0] = 1'b1;
            mode_next = M_IDLE;
            gen       = 1'b1;
          end
        end
      endcase

      if (gen && !is_space(ch)) begin
        if (is_single_punct(ch)) begin
          cand[1]   = make_tok(KIND_PUNCT, ch, 63'd0, char_index, 8'd1);
          cand_v[1] = 1'b1;
        end else begin
          token_start_next   = char_index;
          overflow_flag_next = 1'b0;
          if (is_lead(ch)) begin
            mode_next         = M_OP;
            pending_char_next = ch;
          end else if (is_digit(ch)) begin
            mode_next       = M_NUM;
            number_acc_next = 63'(digit);
            ident_len_next  = 8'd1;
          end else if (is_letter(ch)) begin
            mode_next           = M_IDENT;
            keyword_prefix_next = 48'(ch);
            ident_len_next      = 8'd1;
          end else begin
            cand[1]   = make_tok(KIND_ERROR, ch, 63'd0, char_index, 8'd1);
            cand_v[1] = 1'b1;
          end
        end
      end
    end

    if (end_of_text) begin
      // flush from the state left by this character, then eof and clear
      cand[2]   = flush_tok(mode_next, pending_char_next, token_start_next, ident_len_next,
                            number_acc_next, keyword_prefix_next, overflow_flag_next);
      cand_v[2] = (mode_next != M_IDLE);
      cand[3]   = make_tok(KIND_EOF, 8'd0, 63'd0, char_index_next, 8'd0);
      cand_v[3] = 1'b1;
      mode_next           = M_IDLE;
      pending_char_next   = '0;
      token_start_next    = '0;
      char_index_next     = '0;
      ident_len_next      = '0;
      number_acc_next     = '0;
      keyword_prefix_next = '0;
      overflow_flag_next  = 1'b0;
    end
  end

  // Pack the valid candidates into the bundle in order
  always_comb begin
    q_data = '0;
    n_tok  = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i] && (n_tok < 3'd3)) begin
        q_data.tok[n_tok[1:0]] = cand[i];
        n_tok = n_tok + 3'd1;
      end
    end
    q_data.count = n_tok[1:0];
  end

  assign q_push = take && (n_tok != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= M_IDLE;
      pending_char   <= '0;
      token_start    <= '0;
      char_index     <= '0;
      ident_len      <= '0;
      number_acc     <= '0;
      keyword_prefix <= '0;
      overflow_flag  <= 1'b0;
    end else if (take) begin
      mode           <= mode_next;
      pending_char   <= pending_char_next;
      token_start    <= token_start_next;
      char_index     <= char_index_next;
      ident_len      <= ident_len_next;
      number_acc     <= number_acc_next;
      keyword_prefix <= keyword_prefix_next;
      overflow_flag  <= overflow_flag_next;
    end
  end

endmodule

FILE: src/csl_back.sv
// Serializer: hands out the tokens of the head bundle one per request.
`timescale 1ns / 1ps

module csl_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  csl_pkg::bundle_t  q_head,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output logic [4:0]        kind,
  output logic [7:0]        detail,
  output logic [62:0]       num_value,
  output logic [15:0]       start_pos,
  output logic [7:0]        tok_length,
  output logic              last_of_run
);
  import csl_pkg::*;

  logic [1:0] sub;
  tok_t       cur;
  logic       take;

  assign empty       = q_empty;
  assign cur         = q_head.tok[sub];
  assign kind        = cur.kind;
  assign detail      = cur.detail;
  assign num_value   = cur.num;
  assign start_pos   = cur.start;
  assign tok_length  = cur.len;
  assign last_of_run = (sub == (q_head.count - 2'd1));

  assign take  = pop && !q_empty;
  assign q_pop = take && last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= '0;
    end else if (take) begin
      if (last_of_run) begin
        sub <= '0;
      end else begin
        sub <= sub + 2'd1;
      end
    end
  end

endmodule

FILE: src/c_subset_lexer_top.sv
// Top level of the streaming C subset lexer.
`timescale 1ns / 1ps
//
// Input channel: push/full with ch and end_of_text. A character is taken at
// each clock edge with push high and full low, one per cycle at full rate.
// NUL bytes advance nothing; end_of_text flushes the pending token, adds an
// eof token unless it would be a fourth in the bundle, and resets the scanner.
// Result channel: empty/pop. While empty is low the oldest token sits on the
// result ports; it is taken at an edge with pop high. last_of_run marks the
// last token caused by one character.
// A character's tokens are registered in the bundle queue; the serializer reads its head.
// Throughput: one character per cycle in while full is low; one token per cycle
// out while pop is high. A character that causes several tokens (up to three)
// needs one pop per token; the bundle queue (QDEPTH entries) absorbs this.
// When the receiver stalls the queue fills and full rises; nothing is lost.
// Reset: synchronous, clears the scanner state, the queue and the serializer.

module c_subset_lexer_top #(
  parameter int MAX_IDENT_LEN = csl_pkg::MAX_IDENT_LEN_DEF,
  parameter int POS_WIDTH     = csl_pkg::POS_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  ch,
  input  logic        end_of_text,
  output logic        empty,
  input  logic        pop,
  output logic [4:0]  kind,
  output logic [7:0]  detail,
  output logic [62:0] num_value,
  output logic [15:0] start_pos,
  output logic [7:0]  tok_length,
  output logic        last_of_run
);
  import csl_pkg::*;

  logic    q_push;
  bundle_t q_data;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;
  bundle_t q_head;

  assign full = q_full;

  csl_front #(
    .MAX_IDENT_LEN (MAX_IDENT_LEN),
    .POS_WIDTH     (POS_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .ch          (ch),
    .end_of_text (end_of_text),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_data)
  );

  csl_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_data),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .head    (q_head)
  );

  csl_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .kind        (kind),
    .detail      (detail),
    .num_value   (num_value),
    .start_pos   (start_pos),
    .tok_length  (tok_length),
    .last_of_run (last_of_run)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("bundle written into a full queue");

  a_head_not_blank: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> (q_head.count != 2'd0))
    else $error("queued bundle holds no token");

  a_empty_after_reset: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> empty)
    else $error("result side not empty after reset");

  a_eof_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && (kind == KIND_EOF)) |-> last_of_run)
    else $error("eof token not last of its run");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the C subset lexer: directed and random source text.
`timescale 1ns / 1ps

module tb_top;
  import csl_pkg::*;

  localparam int MAX_ID      = MAX_IDENT_LEN_DEF;
  localparam int QUIET_MAX   = 2000;
  localparam int TAIL_CYCLES = 20;
  localparam logic [63:0] NUM_MAX64 = {1'b0, NUM_LIMIT};

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_OP, SCAN_NUM, SCAN_IDENT} scan_t;

  typedef struct packed {
    tok_t tok;
    logic last;
  } lex_tok_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic [7:0]  ch = 8'd0;
  logic        end_of_text = 1'b0;
  logic        full;
  logic        empty;
  logic [4:0]  kind;
  logic [7:0]  detail;
  logic [62:0] num_value;
  logic [15:0] start_pos;
  logic [7:0]  tok_length;
  logic        last_of_run;

  c_subset_lexer_top dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .ch(ch), .end_of_text(end_of_text),
    .empty(empty), .pop(pop), .kind(kind), .detail(detail), .num_value(num_value),
    .start_pos(start_pos), .tok_length(tok_length), .last_of_run(last_of_run)
  );

  always #6 clk = ~clk;

  string      kw_words [6] = '{"if", "else", "while", "int", "char", "return"};
  logic [4:0] kw_kinds [6] = '{KIND_IF, KIND_ELSE, KIND_WHILE, KIND_TYPE, KIND_TYPE,
                               KIND_RETURN};
  logic [7:0] kw_details [6] = '{8'd0, 8'd0, 8'd0, TYPE_INT, TYPE_CHAR, 8'd0};
  string      op_leads   = "+-*/%^|&=!<>";
  string      op_seconds = "=+-<>!";
  string      puncts     = "(){};,?:[]";

  // Shadow scanner state
  scan_t       lx_mode = SCAN_IDLE;
  logic [7:0]  lx_pend = 8'd0;
  logic [15:0] lx_start = 16'd0;
  logic [15:0] lx_index = 16'd0;
  logic [7:0]  lx_len = 8'd0;
  logic [63:0] lx_acc = 64'd0;
  logic [47:0] lx_prefix = 48'd0;
  logic        lx_ovf = 1'b0;

  lex_tok_t lexed_tokens [$];
  lex_tok_t char_tokens [$];

  int bad_tokens = 0;
  int quiet_cycles = 0;
  int text_items = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_opassign_lead(logic [7:0] c);
    return c inside {"+", "-", "*", "/", "%", "^", "|", "&"};
  endfunction

  function automatic bit is_lookahead_lead(logic [7:0] c);
    return is_opassign_lead(c) || c inside {"=", "!", "<", ">"};
  endfunction

  function automatic bit is_single_punct(logic [7:0] c);
    return c inside {"(", ")", ";", ",", "{", "}", "?", ":", "[", "]"};
  endfunction

  // First byte in the low bits, as the scanner collects it
  function automatic logic [47:0] pack_word(string s);
    logic [47:0] w = 48'd0;
    for (int i = 0; i < s.len() && i < 6; i++) w[8*i +: 8] = s[i];
    return w;
  endfunction

  function automatic void clear_scanner();
    lx_mode   = SCAN_IDLE;
    lx_pend   = 8'd0;
    lx_start  = 16'd0;
    lx_index  = 16'd0;
    lx_len    = 8'd0;
    lx_acc    = 64'd0;
    lx_prefix = 48'd0;
    lx_ovf    = 1'b0;
  endfunction

  function automatic void add_token(logic [4:0] k, logic [7:0] d, logic [62:0] n,
                                    logic [15:0] s, logic [7:0] l);
    lex_tok_t t;
    if (char_tokens.size() >= 3) return;
    t.tok.kind   = k;
    t.tok.detail = d;
    t.tok.num    = n;
    t.tok.start  = s;
    t.tok.len    = l;
    t.last       = 1'b0;
    char_tokens.push_back(t);
  endfunction

  function automatic void flush_ident();
    bit found = 1'b0;
    if (lx_ovf) begin
      add_token(KIND_ERROR, 8'd0, 63'd0, lx_start, lx_len);
      return;
    end
    for (int k = 0; k < 6; k++) begin
      if (!found && lx_len == 8'(kw_words[k].len()) && lx_prefix == pack_word(kw_words[k])) begin
        add_token(kw_kinds[k], kw_details[k], 63'd0, lx_start, lx_len);
        found = 1'b1;
      end
    end
    if (!found) add_token(KIND_IDENT, 8'd0, 63'd0, lx_start, lx_len);
  endfunction

  function automatic void flush_scanner();
    case (lx_mode)
      SCAN_OP:    add_token(KIND_PUNCT, lx_pend, 63'd0, lx_start, 8'd1);
      SCAN_NUM:   add_token(KIND_NUMBER, 8'd0, lx_acc[62:0], lx_start, lx_len);
      SCAN_IDENT: flush_ident();
      default: ;
    endcase
    lx_mode = SCAN_IDLE;
  endfunction

  function automatic void scan_char(logic [7:0] c);
    logic [15:0] idx;
    logic [7:0]  p;
    logic [4:0]  pair;
    logic [63:0] d;
    bit          done = 1'b0;
    bit          paired = 1'b1;
    idx = lx_index;
    lx_index = lx_index + 16'd1;
    case (lx_mode)
      SCAN_OP: begin
        p = lx_pend;
        if (c == "=" && is_opassign_lead(p)) begin
          add_token(KIND_PUNCT, "=", 63'd0, idx, 8'd1);
          add_token(KIND_OPASSIGN, p, 63'd0, lx_start, 8'd1);
          lx_mode = SCAN_IDLE;
          done = 1'b1;
        end else begin
          if (p == "+" && c == "+") pair = KIND_INC;
          else if (p == "-" && c == "-") pair = KIND_DEC;
          else if (p == "=" && c == "=") pair = KIND_EQ;
          else if (p == "!" && c == "=") pair = KIND_NE;
          else if (p == "<" && c == "<") pair = KIND_SHL;
          else if (p == ">" && c == ">") pair = KIND_SHR;
          else paired = 1'b0;
          if (paired) begin
            add_token(pair, 8'd0, 63'd0, lx_start, 8'd2);
            lx_mode = SCAN_IDLE;
            done = 1'b1;
          end else begin
            flush_scanner();
          end
        end
      end
      SCAN_NUM: begin
        if (is_digit(c)) begin
          d = 64'(c) - 64'd48;
          if (lx_acc > (NUM_MAX64 - d) / 64'd10) begin
            lx_acc = NUM_MAX64;
            lx_ovf = 1'b1;
          end else begin
            lx_acc = lx_acc * 64'd10 + d;
          end
          if (lx_len < 8'd255) lx_len = lx_len + 8'd1;
          done = 1'b1;
        end else begin
          flush_scanner();
        end
      end
      SCAN_IDENT: begin
        if (is_letter(c) || is_digit(c)) begin
          if (int'(lx_len) < MAX_ID) begin
            if (lx_len < 8'd6) lx_prefix[8*lx_len +: 8] = c;
            lx_len = lx_len + 8'd1;
          end else begin
            lx_ovf = 1'b1;
          end
          done = 1'b1;
        end else begin
          flush_scanner();
        end
      end
      default: ;
    endcase
    if (!done && !is_space(c)) begin
      if (is_single_punct(c)) begin
        add_token(KIND_PUNCT, c, 63'd0, idx, 8'd1);
      end else begin
        lx_start = idx;
        lx_ovf = 1'b0;
        if (is_lookahead_lead(c)) begin
          lx_mode = SCAN_OP;
          lx_pend = c;
        end else if (is_digit(c)) begin
          lx_mode = SCAN_NUM;
          lx_acc = 64'(c) - 64'd48;
          lx_len = 8'd1;
        end else if (is_letter(c)) begin
          lx_mode = SCAN_IDENT;
          lx_prefix = {40'd0, c};
          lx_len = 8'd1;
        end else begin
          add_token(KIND_ERROR, c, 63'd0, idx, 8'd1);
        end
      end
    end
  endfunction

  // Tokens caused by one accepted request, appended in order
  function automatic void lex_char(logic [7:0] c, logic eot);
    char_tokens.delete();
    if (c != 8'd0) scan_char(c);
    if (eot) begin
      flush_scanner();
      add_token(KIND_EOF, 8'd0, 63'd0, lx_index, 8'd0);
      clear_scanner();
    end
    if (char_tokens.size() > 0) char_tokens[char_tokens.size() - 1].last = 1'b1;
    foreach (char_tokens[i]) lexed_tokens.push_back(char_tokens[i]);
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      bad_tokens++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : tok_check
    lex_tok_t want;
    if (!rst && pop && !empty) begin
      if (lexed_tokens.size() == 0) begin
        bad_tokens++;
        $display("%0t: unexpected token, expected none actual kind %0d start %0d",
                 $time, kind, start_pos);
      end else begin
        want = lexed_tokens.pop_front();
        check_field("kind", 64'(want.tok.kind), 64'(kind));
        check_field("detail", 64'(want.tok.detail), 64'(detail));
        check_field("num_value", 64'(want.tok.num), 64'(num_value));
        check_field("start_pos", 64'(want.tok.start), 64'(start_pos));
        check_field("tok_length", 64'(want.tok.len), 64'(tok_length));
        check_field("last_of_run", 64'(want.last), 64'(last_of_run));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  always @(negedge clk) pop <= !rst && ($urandom_range(0, 99) >= recv_stall_pct);

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_char(input logic [7:0] c, input logic eot);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    ch <= c;
    end_of_text <= eot;
    @(posedge clk);
    while (full) @(posedge clk);
    lex_char(c, eot);
    if (c != 8'd0 && !is_space(c)) text_items++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit eot_last);
    for (int i = 0; i < s.len(); i++) send_char(s[i], eot_last && i == s.len() - 1);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
                                : 8'("A" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  // Identifier (letter first) or digit string of n characters
  task automatic send_word(input int n, input bit digits_only);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      if (digits_only) c = rand_digit();
      else if (i == 0 || $urandom_range(0, 2) != 0) c = rand_letter();
      else c = rand_digit();
      send_char(c, 1'b0);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(negedge clk);
    while (lexed_tokens.size() != 0) @(negedge clk);
  endtask

  task automatic test_punct();
    for (int w = 9; w <= 13; w++) send_char(8'(w), 1'b0);
    send_text("( ) { } [ ] ; , ? :", 1'b0);
    send_char(8'd0, 1'b1);
  endtask

  // Every pair, a compound assignment, and a three-token flush on end
  task automatic test_operators();
    send_text("==!=<<>>++--|=<=", 1'b0);
    send_char("!", 1'b1);
  endtask

  task automatic test_numbers();
    send_text("0 42 9223372036854775807 9223372036854775808x", 1'b1);
  endtask

  task automatic test_keywords();
    send_text("if else while int char return iff Else retur", 1'b1);
  endtask

  task automatic test_errors();
    send_text("@_", 1'b0);
    send_char(8'h7F, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(8'hFF, 1'b1);
  endtask

  // NUL inside a word is skipped without advancing the index
  task automatic test_nul();
    send_char("a", 1'b0);
    send_char(8'd0, 1'b0);
    send_char("b", 1'b0);
    send_char(8'd0, 1'b1);
  endtask

  task automatic test_end_flag();
    send_char(8'd0, 1'b1);
    send_char("x", 1'b0);
    send_char("+", 1'b1);
  endtask

  // One identifier just past the length limit
  task automatic test_long_tokens();
    send_word(MAX_ID + 1, 1'b0);
    send_char(";", 1'b1);
  endtask

  // Mostly well-formed tokens; some noise and end requests that cut tokens short
  task automatic test_random_text(input int n);
    int target;
    int pick;
    target = text_items + n;
    while (text_items < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_text(kw_words[$urandom_range(0, 5)], 1'b0);
      end else if (pick < 35) begin
        send_word($urandom_range(1, 8), 1'b0);
      end else if (pick < 50) begin
        send_word(($urandom_range(0, 7) == 0) ? $urandom_range(18, 22) : $urandom_range(1, 5),
                  1'b1);
      end else if (pick < 70) begin
        send_char(op_leads[$urandom_range(0, 11)], 1'b0);
        if ($urandom_range(0, 1)) send_char(op_seconds[$urandom_range(0, 5)], 1'b0);
      end else if (pick < 80) begin
        send_char(puncts[$urandom_range(0, 9)], 1'b0);
      end else if (pick < 90) begin
        send_char(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        send_char(($urandom_range(0, 1) ? 8'd32 : 8'($urandom_range(9, 13))), 1'b0);
      end
      if ($urandom_range(0, 99) < 40) send_char(" ", 1'b0);
      if ($urandom_range(0, 99) < 7)
        send_char(($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255)), 1'b1);
    end
    send_char(8'd0, 1'b1);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_punct();
    test_operators();
    test_numbers();
    test_keywords();
    test_errors();
    test_nul();
    test_end_flag();
    test_long_tokens();
    test_random_text(20);
    wait_drained();
    send_idle_pct = 52;
    recv_stall_pct = 0;
    test_random_text(20);
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 52;
    test_random_text(20);
    wait_drained();
    send_idle_pct = 8;
    recv_stall_pct = 8;
    test_random_text(20);
    push <= 1'b0;
    while (lexed_tokens.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (bad_tokens == 0 && lexed_tokens.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/csl_pkg.sv
src/csl_queue.sv
src/csl_front.sv
src/csl_back.sv
src/c_subset_lexer_top.sv
tb/tb_top.sv
